// ----- rtl/core/wavhp_pkg.sv -----
// Shared types and constants for the WAV PCM header parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wavhp_pkg;

  localparam int OFFSET_BITS = 32;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [15:0] PCM_FORMAT  = 16'd1;
  localparam logic [15:0] PCM_BITS    = 16'd16;
  localparam logic [4:0]  OUT_BITS    = 5'd16;

  localparam logic [OFFSET_BITS-1:0] POS_RIFF_END = OFFSET_BITS'(3);
  localparam logic [OFFSET_BITS-1:0] POS_WAVE_END = OFFSET_BITS'(11);

  typedef logic [OFFSET_BITS-1:0] pos_t;

  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_BODY = 5'b00100,
    PH_PAD  = 5'b01000,
    PH_DEAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  channel_count;
    logic [31:0] rate_hz;
    logic [4:0]  sample_bits;
    logic [31:0] pcm_offset;
    logic [31:0] pcm_length;
    logic [30:0] frame_total;
  } out_item_t;

endpackage

// ----- rtl/core/wavhp_parser.sv -----
// Byte-wise RIFF/WAVE chunk walker; builds one result on the final byte.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wavhp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  wavhp_pkg::in_item_t  in_item,
  output logic                 res_valid,
  output wavhp_pkg::out_item_t res_item
);
  import wavhp_pkg::*;

  phase_t      phase_r, phase_nxt;
  pos_t        pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [15:0] p_fmt_r, p_fmt_nxt;
  logic [15:0] p_ch_r, p_ch_nxt;
  logic [31:0] p_rate_r, p_rate_nxt;
  logic [15:0] p_bits_r, p_bits_nxt;
  logic [15:0] k_fmt_r, k_fmt_nxt;
  logic [15:0] k_ch_r, k_ch_nxt;
  logic [31:0] k_rate_r, k_rate_nxt;
  logic [15:0] k_bits_r, k_bits_nxt;
  logic [31:0] k_off_r, k_off_nxt;
  logic [31:0] k_len_r, k_len_nxt;
  logic        f_fmt_r, f_fmt_nxt;
  logic        f_data_r, f_data_nxt;
  logic        f_fatal_r, f_fatal_nxt;
  logic        f_over_r, f_over_nxt;

  logic [7:0]  b;
  logic [31:0] tag_sh;
  logic [2:0]  k;
  logic [31:0] off;
  logic [31:0] rem_dec;
  logic        do_commit;
  logic [31:0] commit_len;
  logic        ok;
  out_item_t   res;

  assign b       = in_item.file_byte;
  assign tag_sh  = {tag_r[23:0], b};
  assign k       = rem_r[2:0];
  assign off     = len_r - rem_r;
  assign rem_dec = rem_r - 32'd1;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    tag_nxt     = tag_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    p_fmt_nxt   = p_fmt_r;
    p_ch_nxt    = p_ch_r;
    p_rate_nxt  = p_rate_r;
    p_bits_nxt  = p_bits_r;
    k_fmt_nxt   = k_fmt_r;
    k_ch_nxt    = k_ch_r;
    k_rate_nxt  = k_rate_r;
    k_bits_nxt  = k_bits_r;
    k_off_nxt   = k_off_r;
    k_len_nxt   = k_len_r;
    f_fmt_nxt   = f_fmt_r;
    f_data_nxt  = f_data_r;
    f_fatal_nxt = f_fatal_r;
    f_over_nxt  = f_over_r;
    do_commit   = 1'b0;
    commit_len  = len_r;

    if (&pos_r) begin
      f_over_nxt = 1'b1;
      phase_nxt  = PH_DEAD;
    end else begin
      pos_nxt = pos_r + OFFSET_BITS'(1);
      unique case (phase_r)
        PH_RIFF: begin
          tag_nxt = tag_sh;
          if (pos_r == POS_RIFF_END && tag_sh != TAG_RIFF) begin
            f_fatal_nxt = 1'b1;
            phase_nxt   = PH_DEAD;
          end else if (pos_r == POS_WAVE_END) begin
            if (tag_sh != TAG_WAVE) begin
              f_fatal_nxt = 1'b1;
              phase_nxt   = PH_DEAD;
            end else begin
              phase_nxt = PH_HDR;
              rem_nxt   = '0;
            end
          end
        end
        PH_HDR: begin
          if (!k[2]) tag_nxt = tag_sh;
          else       len_nxt = {b, len_r[31:8]};
          rem_nxt = {29'd0, k + 3'd1};
          if (k == 3'd7) begin
            rem_nxt    = len_nxt;
            commit_len = len_nxt;
            if (len_nxt == 32'd0) do_commit = 1'b1;
            else                  phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (tag_r == TAG_FMT) begin
            unique case (off)
              32'd0:   p_fmt_nxt[7:0]     = b;
              32'd1:   p_fmt_nxt[15:8]    = b;
              32'd2:   p_ch_nxt[7:0]      = b;
              32'd3:   p_ch_nxt[15:8]     = b;
              32'd4:   p_rate_nxt[7:0]    = b;
              32'd5:   p_rate_nxt[15:8]   = b;
              32'd6:   p_rate_nxt[23:16]  = b;
              32'd7:   p_rate_nxt[31:24]  = b;
              32'd14:  p_bits_nxt[7:0]    = b;
              32'd15:  p_bits_nxt[15:8]   = b;
              default: ;
            endcase
          end
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) do_commit = 1'b1;
        end
        PH_PAD: begin
          phase_nxt = PH_HDR;
          rem_nxt   = '0;
        end
        default: ;
      endcase
    end

    if (do_commit) begin
      rem_nxt   = '0;
      phase_nxt = commit_len[0] ? PH_PAD : PH_HDR;
      if (tag_r == TAG_FMT) begin
        if (commit_len < FMT_MIN_LEN) begin
          f_fatal_nxt = 1'b1;
          phase_nxt   = PH_DEAD;
        end else begin
          k_fmt_nxt  = p_fmt_nxt;
          k_ch_nxt   = p_ch_nxt;
          k_rate_nxt = p_rate_nxt;
          k_bits_nxt = p_bits_nxt;
          f_fmt_nxt  = 1'b1;
        end
      end else if (tag_r == TAG_DATA) begin
        k_off_nxt  = 32'(pos_r) + 32'd1 - commit_len;
        k_len_nxt  = commit_len;
        f_data_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    ok = !f_fatal_nxt && !f_over_nxt
      && phase_nxt != PH_RIFF && phase_nxt != PH_DEAD
      && f_fmt_nxt && f_data_nxt
      && k_fmt_nxt == PCM_FORMAT && k_bits_nxt == PCM_BITS
      && (k_ch_nxt == 16'd1 || k_ch_nxt == 16'd2)
      && k_rate_nxt != 32'd0;
    res = '0;
    res.status = 1'b1;
    if (ok) begin
      res.status        = 1'b0;
      res.channel_count = k_ch_nxt[1:0];
      res.rate_hz       = k_rate_nxt;
      res.sample_bits   = OUT_BITS;
      res.pcm_offset    = k_off_nxt;
      res.pcm_length    = k_len_nxt;
      res.frame_total   = k_ch_nxt[1] ? {1'b0, k_len_nxt[31:2]} : k_len_nxt[31:1];
    end
  end

  assign res_valid = take && in_item.final_byte;
  assign res_item  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RIFF;
      pos_r     <= '0;
      rem_r     <= '0;
      f_fmt_r   <= 1'b0;
      f_data_r  <= 1'b0;
      f_fatal_r <= 1'b0;
      f_over_r  <= 1'b0;
    end else if (take) begin
      if (in_item.final_byte) begin
        phase_r   <= PH_RIFF;
        pos_r     <= '0;
        rem_r     <= '0;
        f_fmt_r   <= 1'b0;
        f_data_r  <= 1'b0;
        f_fatal_r <= 1'b0;
        f_over_r  <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        rem_r     <= rem_nxt;
        f_fmt_r   <= f_fmt_nxt;
        f_data_r  <= f_data_nxt;
        f_fatal_r <= f_fatal_nxt;
        f_over_r  <= f_over_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag_r    <= tag_nxt;
      len_r    <= len_nxt;
      p_fmt_r  <= p_fmt_nxt;
      p_ch_r   <= p_ch_nxt;
      p_rate_r <= p_rate_nxt;
      p_bits_r <= p_bits_nxt;
      k_fmt_r  <= k_fmt_nxt;
      k_ch_r   <= k_ch_nxt;
      k_rate_r <= k_rate_nxt;
      k_bits_r <= k_bits_nxt;
      k_off_r  <= k_off_nxt;
      k_len_r  <= k_len_nxt;
    end
  end

endmodule

// ----- rtl/core/wavhp_out_skid.sv -----
// Two-entry result buffer: output register plus skid stage.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wavhp_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wavhp_pkg::out_item_t push_item,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wavhp_pkg::out_item_t out_data
);
  import wavhp_pkg::*;

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      main_v_nxt = skid_v_r;
      main_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end
    if (push) begin
      if (!main_v_nxt) begin
        main_v_nxt = 1'b1;
        main_nxt   = push_item;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

// ----- rtl/core/wav_pcm_header_parser_top.sv -----
// Top level of the WAV PCM16 header parser: chunk walker and result buffer.
// Depends on wavhp_pkg, wavhp_parser and wavhp_out_skid.
//
//   port group   dir  payload      transfer
//   in_*         in   in_item_t    in_valid high, in_stall low
//   out_*        out  out_item_t   out_valid high, out_stall low
//
// One file byte is taken every cycle while in_stall is low; the chunk walker
// updates its state per byte. A result goes to the output register, or to the
// skid stage if that is taken; in_stall is high while both slots are full.
// Synchronous active-low reset returns the walker to the RIFF signature phase.
`timescale 1ns / 1ps

module wav_pcm_header_parser_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wavhp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wavhp_pkg::out_item_t out_data
);
  import wavhp_pkg::*;

  logic      take;
  logic      res_valid;
  out_item_t res_item;
  logic      buf_full;

  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  wavhp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_item   (in_data),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  wavhp_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_item (res_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
